// ===== rtl/core/r2n_pkg.sv =====
package r2n_pkg;

    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int PIXEL_W       = 32;
    localparam int LUMA_ADDR_W   = 24;
    localparam int LUMA_W        = 8;
    localparam int CHROMA_ADDR_W = 25;
    localparam int SUM_W         = 8;
    localparam int ENTRY_W       = 2 * SUM_W;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int DIM_CFG_W   = 13;
    localparam int FMT_W       = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_FORMAT = 2'd2;

    localparam logic [FMT_W-1:0] FMT_RGBA   = 2'd0;
    localparam logic [FMT_W-1:0] FMT_ARGB   = 2'd1;
    localparam logic [FMT_W-1:0] FMT_ABGR   = 2'd2;
    localparam logic [FMT_W-1:0] FMT_RGB565 = 2'd3;

    localparam logic [DIM_CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [DIM_CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;
    localparam logic [FMT_W-1:0]     PIXEL_FORMAT_RST = FMT_RGBA;

endpackage

// ===== rtl/core/r2n_pixel_if.sv =====
interface r2n_pixel_if import r2n_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel_word;

    modport source (output valid, output pixel_word, input ready);
    modport sink (input valid, input pixel_word, output ready);
endinterface

// ===== rtl/core/r2n_result_if.sv =====
interface r2n_result_if import r2n_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [LUMA_ADDR_W-1:0]   luma_addr;
    logic [LUMA_W-1:0]        luma_value;
    logic                     chroma_valid;
    logic [CHROMA_ADDR_W-1:0] chroma_addr;
    logic [SUM_W-1:0]         v_sum;
    logic [SUM_W-1:0]         u_sum;
    logic                     frame_last;

    modport source (
        output valid, output luma_addr, output luma_value, output chroma_valid,
        output chroma_addr, output v_sum, output u_sum, output frame_last,
        input ready
    );
    modport sink (
        input valid, input luma_addr, input luma_value, input chroma_valid,
        input chroma_addr, input v_sum, input u_sum, input frame_last,
        output ready
    );
endinterface

// ===== rtl/core/r2n_cfg_if.sv =====
interface r2n_cfg_if import r2n_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/rgb_to_nv21_converter_unit.sv =====
// Streaming RGB to NV21 (BT.601) converter. Takes one packed pixel per clock in raster
// order unless result.ready holds the pipeline, and returns one result per pixel: the luma
// byte with its offset, and, on the pixel that closes a 2x2 block, the summed V,U pair with
// the offset of its V byte. Sustained rate is one pixel per clock while result.ready stays
// high, set by one read-modify-write of the chroma line store per pixel (one read port, one
// write port, neighbor pixels covered by forwarding). Each pixel passes through stage 1,
// stage 2 and the output register; its result stays offered while result.ready is low. The
// line store holds (MAX_WIDTH+1)/2 block sums and has no clearing pass: the first pixel of
// each block overwrites its entry. Registers may be written only while no pixel is in
// flight; a width or height written mid-frame takes effect from the next pixel.
module rgb_to_nv21_converter_unit import r2n_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    r2n_cfg_if.sink      cfg,
    r2n_pixel_if.sink    pixel,
    r2n_result_if.source result
);

    localparam int CW          = $clog2(MAX_WIDTH);
    localparam int RW          = $clog2(MAX_HEIGHT);
    localparam int DW          = $clog2(MAX_WIDTH + 1);
    localparam int HW          = $clog2(MAX_HEIGHT + 1);
    localparam int BLOCK_SLOTS = (MAX_WIDTH + 1) / 2;
    localparam int SLOT_W      = $clog2(BLOCK_SLOTS);

    // configuration
    logic [DIM_CFG_W-1:0] frame_width_reg;
    logic [DIM_CFG_W-1:0] frame_height_reg;
    logic [FMT_W-1:0]     pixel_format_reg;

    // frame counters
    logic [CW-1:0]          col_count_reg, col_count_next;
    logic [RW-1:0]          row_count_reg, row_count_next;
    logic [LUMA_ADDR_W-1:0] luma_count_reg, luma_count_next;

    logic [DW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic          last_col, last_row;
    logic          pix_acc;

    // stage 1
    logic                   s1_valid_reg;
    logic [PIXEL_W-1:0]     s1_pixel_reg;
    logic [CW-1:0]          s1_col_reg;
    logic [RW-1:0]          s1_row_reg;
    logic [LUMA_ADDR_W-1:0] s1_luma_addr_reg;
    logic                   s1_last_col_reg;
    logic                   s1_last_row_reg;
    logic [DW-1:0]          s1_w_reg;
    logic [HW-1:0]          s1_h_reg;

    logic [7:0]               r8, g8, b8;
    logic [15:0]              y_acc;
    logic [16:0]              v_acc, u_acc;
    logic [DW:0]              row_blocks;
    logic [SLOT_W-1:0]        s1_slot;
    logic [CHROMA_ADDR_W-1:0] s1_wh, s1_prod;

    // stage 2
    logic                     s2_valid_reg;
    logic [LUMA_ADDR_W-1:0]   s2_luma_addr_reg;
    logic [LUMA_W-1:0]        s2_y_reg;
    logic [5:0]               s2_vc_reg, s2_uc_reg;
    logic                     s2_block_start_reg;
    logic                     s2_chroma_valid_reg;
    logic                     s2_frame_last_reg;
    logic [SLOT_W-1:0]        s2_slot_reg;
    logic [CHROMA_ADDR_W-1:0] s2_wh_reg, s2_prod_reg;
    logic                     fwd_reg;
    logic [ENTRY_W-1:0]       fwd_data_reg;
    logic [ENTRY_W-1:0]       mem_rd_reg;

    logic [ENTRY_W-1:0]       entry_old;
    logic [SUM_W-1:0]         v_new, u_new;
    logic [CHROMA_ADDR_W-1:0] chroma_addr_calc;

    // output register
    logic                     out_valid_reg;
    logic [LUMA_ADDR_W-1:0]   out_luma_addr_reg;
    logic [LUMA_W-1:0]        out_luma_value_reg;
    logic                     out_chroma_valid_reg;
    logic [CHROMA_ADDR_W-1:0] out_chroma_addr_reg;
    logic [SUM_W-1:0]         out_v_sum_reg, out_u_sum_reg;
    logic                     out_frame_last_reg;

    logic out_free, s2_go, s2_free, s1_go, s1_free;

    logic [ENTRY_W-1:0] line_mem [BLOCK_SLOTS];

    // pipeline flow
    assign out_free = !out_valid_reg || result.ready;
    assign s2_go    = s2_valid_reg && out_free;
    assign s2_free  = !s2_valid_reg || s2_go;
    assign s1_go    = s1_valid_reg && s2_free;
    assign s1_free  = !s1_valid_reg || s1_go;

    assign pixel.ready = s1_free;
    assign pix_acc     = pixel.valid && s1_free;
    assign cfg.ready   = 1'b1;

    // effective frame size
    always_comb
    begin
        if (frame_width_reg == '0)
            w_eff = DW'(1);
        else if (32'(frame_width_reg) > MAX_WIDTH)
            w_eff = DW'(MAX_WIDTH);
        else
            w_eff = DW'(frame_width_reg);

        if (frame_height_reg == '0)
            h_eff = HW'(1);
        else if (32'(frame_height_reg) > MAX_HEIGHT)
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(frame_height_reg);
    end

    assign last_col = DW'(col_count_reg) >= w_eff - DW'(1);
    assign last_row = HW'(row_count_reg) >= h_eff - HW'(1);

    always_comb
    begin
        col_count_next  = col_count_reg + CW'(1);
        row_count_next  = row_count_reg;
        luma_count_next = luma_count_reg + LUMA_ADDR_W'(1);
        if (last_col)
        begin
            col_count_next = '0;
            if (last_row)
            begin
                row_count_next  = '0;
                luma_count_next = '0;
            end
            else
            begin
                row_count_next = row_count_reg + RW'(1);
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            pixel_format_reg <= PIXEL_FORMAT_RST;
            col_count_reg    <= '0;
            row_count_reg    <= '0;
            luma_count_reg   <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    CFG_FRAME_WIDTH:  frame_width_reg  <= cfg.data;
                    CFG_FRAME_HEIGHT: frame_height_reg <= cfg.data;
                    CFG_PIXEL_FORMAT: pixel_format_reg <= cfg.data[FMT_W-1:0];
                    default: ;
                endcase
            end
            if (pix_acc)
            begin
                col_count_reg  <= col_count_next;
                row_count_reg  <= row_count_next;
                luma_count_reg <= luma_count_next;
            end
            if (s1_free)
                s1_valid_reg <= pixel.valid;
            if (s2_free)
                s2_valid_reg <= s1_valid_reg;
            if (out_free)
                out_valid_reg <= s2_valid_reg;
        end
    end

    // stage 1: unpack and color sums, address products
    always_comb
    begin
        unique case (pixel_format_reg)
            FMT_RGBA:
            begin
                r8 = s1_pixel_reg[31:24];
                g8 = s1_pixel_reg[23:16];
                b8 = s1_pixel_reg[15:8];
            end
            FMT_ARGB:
            begin
                r8 = s1_pixel_reg[23:16];
                g8 = s1_pixel_reg[15:8];
                b8 = s1_pixel_reg[7:0];
            end
            FMT_ABGR:
            begin
                b8 = s1_pixel_reg[23:16];
                g8 = s1_pixel_reg[15:8];
                r8 = s1_pixel_reg[7:0];
            end
            FMT_RGB565:
            begin
                r8 = {s1_pixel_reg[15:11], s1_pixel_reg[15:13]};
                g8 = {s1_pixel_reg[10:5], s1_pixel_reg[10:9]};
                b8 = {s1_pixel_reg[4:0], s1_pixel_reg[4:2]};
            end
            default:
            begin
                r8 = '0;
                g8 = '0;
                b8 = '0;
            end
        endcase
    end

    // bias of 32*1024 + 128 keeps chroma terms positive and folds in the +32
    assign y_acc = 16'(32'd66 * r8 + 32'd129 * g8 + 32'd25 * b8 + 32'd128);
    assign v_acc = 17'(32'd112 * r8 + 32'd32896 - 32'd94 * g8 - 32'd18 * b8);
    assign u_acc = 17'(32'd112 * b8 + 32'd32896 - 32'd38 * r8 - 32'd74 * g8);

    assign row_blocks = ((DW + 1)'(s1_w_reg) + (DW + 1)'(1)) >> 1;
    assign s1_slot    = s1_col_reg[SLOT_W:1];
    assign s1_wh   = CHROMA_ADDR_W'(s1_w_reg) * CHROMA_ADDR_W'(s1_h_reg);
    assign s1_prod = CHROMA_ADDR_W'(s1_row_reg[RW-1:1]) * CHROMA_ADDR_W'(row_blocks);

    // stage 2: accumulate into the block entry
    assign entry_old = fwd_reg ? fwd_data_reg : mem_rd_reg;
    assign v_new = s2_block_start_reg ? SUM_W'(s2_vc_reg)
                                      : entry_old[ENTRY_W-1:SUM_W] + SUM_W'(s2_vc_reg);
    assign u_new = s2_block_start_reg ? SUM_W'(s2_uc_reg)
                                      : entry_old[SUM_W-1:0] + SUM_W'(s2_uc_reg);
    assign chroma_addr_calc = s2_wh_reg
                            + ((s2_prod_reg + CHROMA_ADDR_W'(s2_slot_reg)) << 1);

    // line store; an entry written on the same edge it is read is forwarded
    always_ff @(posedge clk)
    begin
        if (s2_go)
            line_mem[s2_slot_reg] <= {v_new, u_new};
        if (s1_go)
            mem_rd_reg <= line_mem[s1_slot];
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            s1_pixel_reg     <= pixel.pixel_word;
            s1_col_reg       <= col_count_reg;
            s1_row_reg       <= row_count_reg;
            s1_luma_addr_reg <= luma_count_reg;
            s1_last_col_reg  <= last_col;
            s1_last_row_reg  <= last_row;
            s1_w_reg         <= w_eff;
            s1_h_reg         <= h_eff;
        end
        if (s1_go)
        begin
            s2_luma_addr_reg    <= s1_luma_addr_reg;
            s2_y_reg            <= y_acc[15:8] + LUMA_W'(16);
            s2_vc_reg           <= v_acc[15:10];
            s2_uc_reg           <= u_acc[15:10];
            s2_block_start_reg  <= !s1_col_reg[0] && !s1_row_reg[0];
            s2_chroma_valid_reg <= (s1_col_reg[0] || s1_last_col_reg)
                                && (s1_row_reg[0] || s1_last_row_reg);
            s2_frame_last_reg   <= s1_last_col_reg && s1_last_row_reg;
            s2_slot_reg         <= s1_slot;
            s2_wh_reg           <= s1_wh;
            s2_prod_reg         <= s1_prod;
            fwd_reg             <= s2_go && (s2_slot_reg == s1_slot);
            fwd_data_reg        <= {v_new, u_new};
        end
        if (s2_go)
        begin
            out_luma_addr_reg    <= s2_luma_addr_reg;
            out_luma_value_reg   <= s2_y_reg;
            out_chroma_valid_reg <= s2_chroma_valid_reg;
            out_frame_last_reg   <= s2_frame_last_reg;
            if (s2_chroma_valid_reg)
            begin
                out_chroma_addr_reg <= chroma_addr_calc;
                out_v_sum_reg       <= v_new;
                out_u_sum_reg       <= u_new;
            end
            else
            begin
                out_chroma_addr_reg <= '0;
                out_v_sum_reg       <= '0;
                out_u_sum_reg       <= '0;
            end
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.luma_addr    = out_luma_addr_reg;
    assign result.luma_value   = out_luma_value_reg;
    assign result.chroma_valid = out_chroma_valid_reg;
    assign result.chroma_addr  = out_chroma_addr_reg;
    assign result.v_sum        = out_v_sum_reg;
    assign result.u_sum        = out_u_sum_reg;
    assign result.frame_last   = out_frame_last_reg;

`ifndef ASSERT_OFF
    a_counters_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        pix_acc && last_col && last_row
        |=> col_count_reg == '0 && row_count_reg == '0 && luma_count_reg == '0)
        else $error("counters not cleared after last pixel of frame");

    a_no_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_chroma_valid_reg
        |-> out_chroma_addr_reg == '0 && out_v_sum_reg == '0 && out_u_sum_reg == '0)
        else $error("chroma fields not zero on result without chroma");

    a_last_has_chroma: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_frame_last_reg |-> out_chroma_valid_reg)
        else $error("last pixel of frame does not close a chroma block");

    a_luma_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_luma_value_reg >= LUMA_W'(16)
                       && out_luma_value_reg <= LUMA_W'(235))
        else $error("luma out of range");

    a_fwd_only_same_slot: assert property (@(posedge clk) disable iff (!rst_n)
        s1_go && s2_go && s2_slot_reg == s1_slot |=> fwd_reg)
        else $error("missed forward of a block entry");
`endif

endmodule
